FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// consequence that follows in the cycle after the trigger
`define ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/stf_pkg.sv
package stf_pkg;

	localparam int WINDOW_MAX_DEF  = 32;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int OUT_BITS        = 24;
	localparam int CFG_BITS        = 6;
	localparam int FRAC_BITS       = 8;
	localparam int TRIM_COUNT      = 2;
	localparam int WINDOW_RESET    = 8;

endpackage

FILE: hdl/stf_in_if.sv
interface stf_in_if #(
	parameter int SAMPLE_BITS = stf_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

FILE: hdl/stf_out_if.sv
interface stf_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [stf_pkg::OUT_BITS-1:0] smoothed_value;

	modport source (output valid, output smoothed_value, input ready);
	modport sink (input valid, input smoothed_value, output ready);
endinterface

FILE: hdl/sliding_trimmed_mean_filter.sv
// a new sample is taken only in idle, once the previous result is loaded into the output register;
// each result is set by the scan of the window memory (one read a cycle, single read port)
// followed by the restoring divider that retires two quotient bits a cycle
// arst_n clears control state: window size returns to 8 (WINDOW_MAX if smaller), window empty, output not valid
`include "assert_macros.svh"

module sliding_trimmed_mean_filter #(
	parameter int WINDOW_MAX  = stf_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = stf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [stf_pkg::CFG_BITS-1:0] cfg_wdata,
	stf_in_if.sink                       sample_ch,
	stf_out_if.source                    result_ch
);

	localparam int IDX_W     = $clog2(WINDOW_MAX);
	localparam int CNT_W     = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W     = SAMPLE_BITS + $clog2(WINDOW_MAX);
	localparam int NUM_W     = SUM_W + stf_pkg::FRAC_BITS;
	localparam int DIV_STEPS = (NUM_W + 1) / 2;
	localparam int DIV_W     = 2 * DIV_STEPS;
	localparam int DCNT_W    = $clog2(DIV_STEPS);
	localparam int RES_W     = (DIV_W + 1 > stf_pkg::OUT_BITS) ? DIV_W + 1 : stf_pkg::OUT_BITS;
	localparam int WS_RESET  = (stf_pkg::WINDOW_RESET > WINDOW_MAX) ?
		WINDOW_MAX : stf_pkg::WINDOW_RESET;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_TRIM,
		S_DIV,
		S_DONE
	} state_t;

	state_t                            state_q;
	logic [CNT_W-1:0]                  ws_q;
	logic [CNT_W-1:0]                  fill_q;
	logic [IDX_W-1:0]                  oldest_q;
	logic [IDX_W-1:0]                  rd_idx_q;
	logic                              rd_vld_s1;
	logic                              rd_first_s1;
	logic [DCNT_W-1:0]                 dcnt_q;
	logic                              out_valid_q;
	logic signed [stf_pkg::OUT_BITS-1:0] out_data_q;

	logic signed [SAMPLE_BITS-1:0]     window_mem_q [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0]     rd_data_s1;
	logic signed [SUM_W-1:0]           sum_q;
	logic signed [SAMPLE_BITS-1:0]     lo_q;
	logic signed [SAMPLE_BITS-1:0]     hi_q;
	logic [DIV_W-1:0]                  num_q;
	logic [CNT_W-1:0]                  rem_q;
	logic [CNT_W-1:0]                  div_q;
	logic                              neg_q;

	logic                              mem_we;
	logic [IDX_W-1:0]                  wr_slot;
	logic                              window_full;
	logic [CNT_W-1:0]                  ws_wr;
	logic signed [SUM_W-1:0]           sum_nx;
	logic signed [SAMPLE_BITS-1:0]     lo_nx;
	logic signed [SAMPLE_BITS-1:0]     hi_nx;
	logic                              trim_en;
	logic signed [SUM_W-1:0]           tsum;
	logic [SUM_W-1:0]                  tmag;
	logic [CNT_W-1:0]                  divisor;
	logic [CNT_W-1:0]                  rem_nx;
	logic [DIV_W-1:0]                  num_nx;
	logic signed [DIV_W:0]             res_s;
	logic signed [RES_W-1:0]           res_ext;
	logic                              out_load;

	assign sample_ch.ready          = (state_q == S_IDLE);
	assign result_ch.valid          = out_valid_q;
	assign result_ch.smoothed_value = out_data_q;

	assign mem_we      = sample_ch.valid && sample_ch.ready;
	assign window_full = (fill_q >= ws_q);
	assign wr_slot     = window_full ? oldest_q : fill_q[IDX_W-1:0];
	assign out_load    = (state_q == S_DONE) && (!out_valid_q || result_ch.ready);

	// clamp written window size to 1..WINDOW_MAX
	always_comb begin
		if (cfg_wdata == '0) begin
			ws_wr = CNT_W'(1);
		end else if (32'(cfg_wdata) > 32'(WINDOW_MAX)) begin
			ws_wr = CNT_W'(WINDOW_MAX);
		end else begin
			ws_wr = CNT_W'(cfg_wdata);
		end
	end

	// running sum, min and max over the scanned entries
	always_comb begin
		if (rd_first_s1) begin
			sum_nx = SUM_W'(rd_data_s1);
			lo_nx  = rd_data_s1;
			hi_nx  = rd_data_s1;
		end else begin
			sum_nx = sum_q + SUM_W'(rd_data_s1);
			lo_nx  = (rd_data_s1 < lo_q) ? rd_data_s1 : lo_q;
			hi_nx  = (rd_data_s1 > hi_q) ? rd_data_s1 : hi_q;
		end
	end

	// trimmed sum (untrimmed while fill is at most TRIM_COUNT), its magnitude and the divisor
	always_comb begin
		trim_en = (fill_q > CNT_W'(stf_pkg::TRIM_COUNT));
		tsum    = trim_en ? (sum_q - SUM_W'(lo_q) - SUM_W'(hi_q)) : sum_q;
		tmag    = tsum[SUM_W-1] ? (~tsum + SUM_W'(1)) : tsum;
		divisor = trim_en ? (fill_q - CNT_W'(stf_pkg::TRIM_COUNT)) : fill_q;
	end

	// two restoring division steps per cycle
	always_comb begin
		logic [CNT_W:0]   sh_v;
		logic [CNT_W-1:0] rem_v;
		logic [DIV_W-1:0] num_v;
		rem_v = rem_q;
		num_v = num_q;
		for (int k = 0; k < 2; k++) begin
			sh_v = {rem_v, num_v[DIV_W-1]};
			if (sh_v >= {1'b0, div_q}) begin
				rem_v = CNT_W'(sh_v - {1'b0, div_q});
				num_v = {num_v[DIV_W-2:0], 1'b1};
			end else begin
				rem_v = sh_v[CNT_W-1:0];
				num_v = {num_v[DIV_W-2:0], 1'b0};
			end
		end
		rem_nx = rem_v;
		num_nx = num_v;
	end

	assign res_s   = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
	assign res_ext = RES_W'(res_s);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			window_mem_q[wr_slot] <= sample_ch.sample;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= window_mem_q[rd_idx_q];
		if (rd_vld_s1) begin
			sum_q <= sum_nx;
			lo_q  <= lo_nx;
			hi_q  <= hi_nx;
		end
		if (state_q == S_TRIM) begin
			num_q <= DIV_W'({tmag, {stf_pkg::FRAC_BITS{1'b0}}});
			rem_q <= '0;
			div_q <= divisor;
			neg_q <= tsum[SUM_W-1];
		end else if (state_q == S_DIV) begin
			num_q <= num_nx;
			rem_q <= rem_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ws_q        <= CNT_W'(WS_RESET);
			fill_q      <= '0;
			oldest_q    <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			rd_vld_s1   <= (state_q == S_SCAN);
			rd_first_s1 <= (state_q == S_SCAN) && (rd_idx_q == '0);
			if (result_ch.valid && result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (sample_ch.valid) begin
						if (window_full) begin
							oldest_q <= (CNT_W'(oldest_q) + CNT_W'(1) == ws_q) ?
								'0 : oldest_q + IDX_W'(1);
						end else begin
							fill_q <= fill_q + CNT_W'(1);
						end
						rd_idx_q <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
					if (CNT_W'(rd_idx_q) == fill_q - CNT_W'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_TRIM;
				end
				S_TRIM: begin
					dcnt_q  <= DCNT_W'(DIV_STEPS - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (dcnt_q == '0) begin
						state_q <= S_DONE;
					end else begin
						dcnt_q <= dcnt_q - DCNT_W'(1);
					end
				end
				S_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_ext[stf_pkg::OUT_BITS-1:0];
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// window restart on a register write
			if (cfg_we) begin
				ws_q     <= ws_wr;
				fill_q   <= '0;
				oldest_q <= '0;
			end
		end
	end

	`ASSERT_ALWAYS(a_fill_bound, fill_q <= ws_q, "fill count above window size")
	`ASSERT_ALWAYS(a_oldest_bound, CNT_W'(oldest_q) < ws_q, "oldest slot outside window")
	`ASSERT_NEXT(a_accept_scan, sample_ch.valid && sample_ch.ready, state_q == S_SCAN,
		"accepted sample did not start a scan")
	`ASSERT_NEXT(a_done_out, out_load, result_ch.valid && state_q == S_IDLE,
		"finished quotient not presented")

endmodule

FILE: tb/sv/tb_sliding_trimmed_mean_filter.sv
`timescale 1ns / 1ps

module tb_sliding_trimmed_mean_filter;

	localparam int WIN_MAX      = stf_pkg::WINDOW_MAX_DEF;
	localparam int SB           = stf_pkg::SAMPLE_BITS_DEF;
	localparam longint SCALE    = longint'(1) << stf_pkg::FRAC_BITS;
	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_CYCLES = 80;
	localparam int DIRECTED_LEN = 29;
	localparam int PLAN_LEN     = 7;

	typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

	typedef struct packed {
		row_kind_t                            kind;
		logic [stf_pkg::CFG_BITS-1:0]         cfg;
		logic signed [SB-1:0]                 smp;
		logic                                 typed;
		logic signed [stf_pkg::OUT_BITS-1:0]  want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [stf_pkg::CFG_BITS-1:0] cfg_wdata;

	stf_in_if  sample_ch ();
	stf_out_if result_ch ();

	sliding_trimmed_mean_filter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	always #6 clk = ~clk;

	// predictor state
	logic signed [SB-1:0] win_store [WIN_MAX];
	int unsigned win_fill;
	int unsigned win_oldest;
	int unsigned win_len;
	int unsigned widest_window;

	logic signed [stf_pkg::OUT_BITS-1:0] pending_means [$];
	logic signed [SB-1:0] last_sample;

	int samples_sent;
	int means_checked;
	int window_writes;
	int mismatches;
	int quiet_cycles;
	bit sender_quiet;
	bit hold_request;
	bit hold_done;

	plan_row_t directed_plan [DIRECTED_LEN] = '{
		'{ROW_SAMPLE, 6'd0,  16'sh7FFF, 1'b1, 24'sh7FFF00},
		'{ROW_SAMPLE, 6'd0,  16'sh8000, 1'b1, -24'sd128},
		'{ROW_SAMPLE, 6'd0,  16'sd0,    1'b1, 24'sd0},
		'{ROW_SAMPLE, 6'd0,  16'sd100,  1'b0, 24'sd0},
		'{ROW_SAMPLE, 6'd0,  -16'sd100, 1'b0, 24'sd0},
		'{ROW_SAMPLE, 6'd0,  16'sd100,  1'b0, 24'sd0},
		'{ROW_SAMPLE, 6'd0,  16'sd1,    1'b0, 24'sd0},
		'{ROW_SAMPLE, 6'd0,  -16'sd1,   1'b0, 24'sd0},
		'{ROW_SAMPLE, 6'd0,  16'sd7,    1'b0, 24'sd0},
		'{ROW_CONFIG, 6'd0,  16'sd0,    1'b0, 24'sd0},
		'{ROW_SAMPLE, 6'd0,  16'sh8000, 1'b1, 24'sh800000},
		'{ROW_SAMPLE, 6'd0,  16'sh7FFF, 1'b1, 24'sh7FFF00},
		'{ROW_CONFIG, 6'd2,  16'sd0,    1'b0, 24'sd0},
		'{ROW_SAMPLE, 6'd0,  16'sd7,    1'b1, 24'sd1792},
		'{ROW_SAMPLE, 6'd0,  16'sd8,    1'b1, 24'sd1920},
		'{ROW_SAMPLE, 6'd0,  -16'sd3,   1'b1, 24'sd640},
		'{ROW_CONFIG, 6'd3,  16'sd0,    1'b0, 24'sd0},
		'{ROW_SAMPLE, 6'd0,  16'sd5,    1'b1, 24'sd1280},
		'{ROW_SAMPLE, 6'd0,  16'sd5,    1'b1, 24'sd1280},
		'{ROW_SAMPLE, 6'd0,  16'sd5,    1'b1, 24'sd1280},
		'{ROW_CONFIG, 6'd63, 16'sd0,    1'b0, 24'sd0},
		'{ROW_SAMPLE, 6'd0,  -16'sd7,   1'b0, 24'sd0},
		'{ROW_SAMPLE, 6'd0,  16'sd9,    1'b0, 24'sd0},
		'{ROW_SAMPLE, 6'd0,  -16'sd7,   1'b0, 24'sd0},
		'{ROW_SAMPLE, 6'd0,  16'sd9,    1'b0, 24'sd0},
		'{ROW_CONFIG, 6'd32, 16'sd0,    1'b0, 24'sd0},
		'{ROW_SAMPLE, 6'd0,  16'sh8000, 1'b0, 24'sd0},
		'{ROW_SAMPLE, 6'd0,  16'sh7FFF, 1'b0, 24'sd0},
		'{ROW_SAMPLE, 6'd0,  16'sh8000, 1'b0, 24'sd0}
	};

	logic [stf_pkg::CFG_BITS-1:0] window_plan [PLAN_LEN] =
		'{6'd1, 6'd2, 6'd3, 6'd32, 6'd0, 6'd63, 6'd33};

	function automatic void set_window(input logic [stf_pkg::CFG_BITS-1:0] raw);
		int unsigned n;
		n = raw;
		if (n < 1)
			n = 1;
		if (n > WIN_MAX)
			n = WIN_MAX;
		win_len = n;
		win_fill = 0;
		win_oldest = 0;
		if (n > widest_window)
			widest_window = n;
	endfunction

	function automatic logic signed [stf_pkg::OUT_BITS-1:0] trimmed_mean(
			input logic signed [SB-1:0] s);
		longint acc;
		longint lo;
		longint hi;
		longint divisor;
		if (win_fill < win_len) begin
			win_store[win_fill] = s;
			win_fill++;
		end else begin
			win_store[win_oldest] = s;
			win_oldest = (win_oldest + 1) % win_len;
		end
		acc = 0;
		lo = win_store[0];
		hi = win_store[0];
		for (int unsigned i = 0; i < win_fill; i++) begin
			acc += win_store[i];
			if (win_store[i] < lo)
				lo = win_store[i];
			if (win_store[i] > hi)
				hi = win_store[i];
		end
		if (win_fill <= stf_pkg::TRIM_COUNT) begin
			divisor = win_fill;
		end else begin
			acc = acc - lo - hi;
			divisor = longint'(win_fill) - stf_pkg::TRIM_COUNT;
		end
		if (divisor < 1)
			divisor = 1;
		return stf_pkg::OUT_BITS'((acc * SCALE) / divisor);
	endfunction

	function automatic logic signed [SB-1:0] random_sample();
		logic signed [SB-1:0] v;
		case ($urandom_range(9))
			0, 1: v = last_sample;
			2: begin
				case ($urandom_range(3))
					0: v = 16'sh8000;
					1: v = 16'sh7FFF;
					2: v = 16'sd0;
					default: v = -16'sd1;
				endcase
			end
			3, 4: v = SB'(int'($urandom_range(20)) - 10);
			default: v = SB'($urandom());
		endcase
		last_sample = v;
		return v;
	endfunction

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic send_sample(input logic signed [SB-1:0] s, input logic typed,
			input logic signed [stf_pkg::OUT_BITS-1:0] want);
		logic signed [stf_pkg::OUT_BITS-1:0] p;
		if (!sender_quiet && $urandom_range(99) < 17) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= s;
		do @(posedge clk); while (!sample_ch.ready);
		p = trimmed_mean(s);
		pending_means.push_back(typed ? want : p);
		samples_sent++;
	endtask

	// only while nothing is in flight
	task automatic write_window(input logic [stf_pkg::CFG_BITS-1:0] v);
		sample_ch.valid <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		set_window(v);
		window_writes++;
	endtask

	task automatic check_result(input logic signed [stf_pkg::OUT_BITS-1:0] got);
		logic signed [stf_pkg::OUT_BITS-1:0] want;
		if (pending_means.size() == 0) begin
			report($sformatf("result %0d with no sample outstanding", got));
		end else begin
			want = pending_means.pop_front();
			if (got !== want)
				report($sformatf("result %0d, expected %0d", got, want));
		end
		means_checked++;
	endtask

	// stimulus
	initial begin
		int ph;
		int n;
		int random_sent;
		logic [stf_pkg::CFG_BITS-1:0] wv;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		sender_quiet = 1'b0;
		hold_request = 1'b0;
		last_sample = '0;
		samples_sent = 0;
		window_writes = 0;
		mismatches = 0;
		widest_window = 0;
		random_sent = 0;
		set_window(stf_pkg::CFG_BITS'(stf_pkg::WINDOW_RESET));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[r]) begin
			if (directed_plan[r].kind == ROW_CONFIG)
				write_window(directed_plan[r].cfg);
			else
				send_sample(directed_plan[r].smp, directed_plan[r].typed, directed_plan[r].want);
		end

		ph = 0;
		while (random_sent < RANDOM_ITEMS) begin
			wv = (ph < PLAN_LEN) ? window_plan[ph] : stf_pkg::CFG_BITS'($urandom_range(63));
			write_window(wv);
			if (ph == 3)
				hold_request = 1'b1;
			sender_quiet = (ph == 5);
			n = 2 * win_len + $urandom_range(10);
			for (int k = 0; k < n && random_sent < RANDOM_ITEMS; k++) begin
				send_sample(random_sample(), 1'b0, '0);
				random_sent++;
			end
			ph++;
		end
		sample_ch.valid <= 1'b0;

		while (pending_means.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d samples over %0d window writes (widest %0d), %0d results checked",
			samples_sent, window_writes, widest_window, means_checked);
		$display("includes a %0d-cycle output stall with the input backed up", HOLD_CYCLES);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// result side
	initial begin
		int hold_left;
		hold_left = 0;
		hold_done = 1'b0;
		means_checked = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				check_result(result_ch.smoothed_value);
			if (hold_request && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= (means_checked >= 200 && means_checked < 260)
					|| ($urandom_range(99) >= 17);
			end
		end
	end

	// watchdog on transaction activity
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("no transaction for %0d cycles, %0d results outstanding",
				quiet_cycles, pending_means.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial quiet_cycles = 0;

endmodule

FILE: sim.f
+incdir+hdl
hdl/stf_pkg.sv
hdl/stf_in_if.sv
hdl/stf_out_if.sv
hdl/sliding_trimmed_mean_filter.sv
tb/sv/tb_sliding_trimmed_mean_filter.sv
